// File: rtl/core/part_pkg.sv
// Package for the pid address range table: widths, codes and shared types.
`timescale 1ns / 1ps
`default_nettype none
package part_pkg;

  localparam int unsigned TableEntriesDefault = 16;
  localparam int unsigned PidW  = 32;
  localparam int unsigned AddrW = 64;

  typedef enum logic [1:0] {
    REQ_INSERT       = 2'd0,
    REQ_LOOKUP       = 2'd1,
    REQ_REMOVE_RANGE = 2'd2,
    REQ_REMOVE_PID   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_WRITE,
    CS_DONE
  } ctrl_state_e;

  typedef struct packed {
    req_type_e         req_type;
    logic [PidW-1:0]   pid;
    logic [AddrW-1:0]  start_addr;
    logic [AddrW-1:0]  end_addr;
    logic [AddrW-1:0]  probe_address;
  } req_t;

  typedef struct packed {
    logic [PidW-1:0]   pid;
    logic [AddrW-1:0]  start_addr;
    logic [AddrW-1:0]  end_addr;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic pid_hit;
    logic triple_hit;
    logic range_hit;
  } match_t;

  typedef struct packed {
    status_e status;
    logic    found;
  } rsp_t;

endpackage
`default_nettype wire

// File: rtl/core/part_if.sv
// Request and response channel interfaces of the pid address range table.
`timescale 1ns / 1ps
`default_nettype none
interface part_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  logic [part_pkg::PidW-1:0]  pid;
  logic [part_pkg::AddrW-1:0] start_addr;
  logic [part_pkg::AddrW-1:0] end_addr;
  logic [part_pkg::AddrW-1:0] probe_address;

  modport source (output valid, req_type, pid, start_addr, end_addr, probe_address,
                  input ready);
  modport sink   (input valid, req_type, pid, start_addr, end_addr, probe_address,
                  output ready);
endinterface

interface part_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       found;

  modport source (output valid, status, found, input ready);
  modport sink   (input valid, status, found, output ready);
endinterface
`default_nettype wire

// File: rtl/core/part_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module part_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/part_match.sv
// Compares one stored entry against the request held in the controller.
`timescale 1ns / 1ps
`default_nettype none
module part_match (
  input  wire part_pkg::entry_t entry_i,
  input  wire part_pkg::req_t   req_i,
  output part_pkg::match_t      match_o
);

  logic pid_eq;

  assign pid_eq = (entry_i.pid == req_i.pid);

  assign match_o.pid_hit    = pid_eq;
  assign match_o.triple_hit = pid_eq && (entry_i.start_addr == req_i.start_addr)
                                     && (entry_i.end_addr == req_i.end_addr);
  assign match_o.range_hit  = pid_eq && (req_i.probe_address >= entry_i.start_addr)
                                     && (req_i.probe_address <= entry_i.end_addr);

endmodule
`default_nettype wire

// File: rtl/core/part_ctrl.sv
// Scan sequencer: valid bits, table scan, decision and write-back.
`timescale 1ns / 1ps
`default_nettype none
module part_ctrl #(
  parameter int unsigned TABLE_ENTRIES = part_pkg::TableEntriesDefault,
  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  input  wire part_pkg::req_t    req_i,
  output part_pkg::req_t         req_o,
  output logic                   ram_re_o,
  output logic [IdxW-1:0]        ram_raddr_o,
  output logic                   ram_we_o,
  output logic [IdxW-1:0]        ram_waddr_o,
  output part_pkg::entry_t       ram_wdata_o,
  input  wire part_pkg::match_t  match_i,
  input  wire logic              rsp_free_i,
  output logic                   done_o,
  output part_pkg::rsp_t         rsp_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  part_pkg::ctrl_state_e state_q, state_d;
  part_pkg::req_t        req_q, req_d;
  part_pkg::status_e     status_q, status_d;
  logic                  found_q, found_d;
  logic                  dup_q, dup_d;
  logic                  free_found_q, free_found_d;
  logic [IdxW-1:0]       free_idx_q, free_idx_d;
  logic [IdxW-1:0]       rd_idx_q, rd_idx_d;
  logic                  issue_done_q, issue_done_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]       cmp_idx_q, cmp_idx_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;

  logic bad_range;
  logic skip_scan;
  logic scan_end;
  logic cur_valid;
  logic ram_re;

  assign bad_range = (req_i.start_addr >= req_i.end_addr);
  assign skip_scan = bad_range && ((req_i.req_type == part_pkg::REQ_INSERT) ||
                                   (req_i.req_type == part_pkg::REQ_REMOVE_RANGE));
  assign scan_end  = cmp_vld_q && (cmp_idx_q == LastIdx);
  assign cur_valid = valid_q[cmp_idx_q];
  assign ram_re    = (state_q == part_pkg::CS_SCAN) && !issue_done_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      part_pkg::CS_IDLE: begin
        if (req_valid_i) begin
          state_d = skip_scan ? part_pkg::CS_DONE : part_pkg::CS_SCAN;
        end
      end
      part_pkg::CS_SCAN: begin
        if (scan_end) begin
          state_d = (req_q.req_type == part_pkg::REQ_INSERT) ? part_pkg::CS_WRITE
                                                             : part_pkg::CS_DONE;
        end
      end
      part_pkg::CS_WRITE: state_d = part_pkg::CS_DONE;
      part_pkg::CS_DONE: begin
        if (rsp_free_i) begin
          state_d = part_pkg::CS_IDLE;
        end
      end
      default: state_d = part_pkg::CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready_o  = (state_q == part_pkg::CS_IDLE);
    ram_re_o     = ram_re;
    ram_raddr_o  = rd_idx_q;
    ram_we_o     = (state_q == part_pkg::CS_WRITE) && !dup_q && free_found_q;
    ram_waddr_o  = free_idx_q;
    ram_wdata_o.pid        = req_q.pid;
    ram_wdata_o.start_addr = req_q.start_addr;
    ram_wdata_o.end_addr   = req_q.end_addr;
    done_o       = (state_q == part_pkg::CS_DONE) && rsp_free_i;
    rsp_o.status = status_q;
    rsp_o.found  = found_q;
    req_o        = req_q;
  end

  // datapath
  always_comb begin
    req_d        = req_q;
    status_d     = status_q;
    found_d      = found_q;
    dup_d        = dup_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    rd_idx_d     = rd_idx_q;
    issue_done_d = issue_done_q;
    valid_d      = valid_q;
    cmp_vld_d    = ram_re;
    cmp_idx_d    = rd_idx_q;

    case (state_q)
      part_pkg::CS_IDLE: begin
        if (req_valid_i) begin
          req_d        = req_i;
          status_d     = (skip_scan && (req_i.req_type == part_pkg::REQ_INSERT))
                         ? part_pkg::STATUS_INVALID : part_pkg::STATUS_OK;
          found_d      = 1'b0;
          dup_d        = 1'b0;
          free_found_d = 1'b0;
          free_idx_d   = '0;
          rd_idx_d     = '0;
          issue_done_d = 1'b0;
        end
      end
      part_pkg::CS_SCAN: begin
        if (ram_re) begin
          if (rd_idx_q == LastIdx) begin
            issue_done_d = 1'b1;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
        if (cmp_vld_q) begin
          case (req_q.req_type)
            part_pkg::REQ_INSERT: begin
              if (cur_valid && match_i.triple_hit) begin
                dup_d = 1'b1;
              end
              if (!cur_valid && !free_found_q) begin
                free_found_d = 1'b1;
                free_idx_d   = cmp_idx_q;
              end
            end
            part_pkg::REQ_LOOKUP: begin
              if (cur_valid && match_i.range_hit) begin
                found_d = 1'b1;
              end
            end
            part_pkg::REQ_REMOVE_RANGE: begin
              if (cur_valid && match_i.triple_hit && !found_q) begin
                valid_d[cmp_idx_q] = 1'b0;
                found_d            = 1'b1;
              end
            end
            part_pkg::REQ_REMOVE_PID: begin
              if (cur_valid && match_i.pid_hit) begin
                valid_d[cmp_idx_q] = 1'b0;
                found_d            = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      part_pkg::CS_WRITE: begin
        if (!dup_q) begin
          if (free_found_q) begin
            valid_d[free_idx_q] = 1'b1;
          end else begin
            status_d = part_pkg::STATUS_FULL;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= part_pkg::CS_IDLE;
      valid_q   <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    status_q     <= status_d;
    found_q      <= found_d;
    dup_q        <= dup_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    rd_idx_q     <= rd_idx_d;
    issue_done_q <= issue_done_d;
    cmp_idx_q    <= cmp_idx_d;
  end

endmodule
`default_nettype wire

// File: rtl/core/pid_address_range_table.sv
// From the accepting edge, an insert or remove-range with start >= end goes straight to the
// done state; other requests scan the entry RAM one entry per cycle, and an insert then
// passes a decision and write-back state before the response register is loaded.
// One request at a time: a new one is taken only once the last has left the done state;
// the next is taken while the response register still waits, then the done state stalls.
// Reset clears the valid bits at once; the entry RAM itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module pid_address_range_table #(
  parameter int unsigned TABLE_ENTRIES = part_pkg::TableEntriesDefault,
  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  part_req_if.sink    req_i,
  part_rsp_if.source  rsp_o
);

  part_pkg::req_t   req_in;
  part_pkg::req_t   req_held;
  part_pkg::entry_t ram_wdata;
  part_pkg::entry_t ram_rdata;
  part_pkg::match_t match;
  part_pkg::rsp_t   rsp_next;
  part_pkg::rsp_t   rsp_q;
  logic             ram_re;
  logic             ram_we;
  logic [IdxW-1:0]  ram_raddr;
  logic [IdxW-1:0]  ram_waddr;
  logic             done;
  logic             rsp_free;
  logic             rsp_valid_q, rsp_valid_d;

  assign req_in.req_type      = part_pkg::req_type_e'(req_i.req_type);
  assign req_in.pid           = req_i.pid;
  assign req_in.start_addr    = req_i.start_addr;
  assign req_in.end_addr      = req_i.end_addr;
  assign req_in.probe_address = req_i.probe_address;

  assign rsp_free = !rsp_valid_q || rsp_o.ready;

  part_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req_in),
    .req_o       (req_held),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .match_i     (match),
    .rsp_free_i  (rsp_free),
    .done_o      (done),
    .rsp_o       (rsp_next)
  );

  part_ram #(
    .Width (part_pkg::EntryW),
    .Depth (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  part_match u_match (
    .entry_i (ram_rdata),
    .req_i   (req_held),
    .match_o (match)
  );

  // response register
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (done) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.status = rsp_q.status;
  assign rsp_o.found  = rsp_q.found;

endmodule
`default_nettype wire

// File: tb/sv/pid_address_range_table_tb.sv
// Testbench for the pid address range table: directed table, random requests, scoreboard.
`timescale 1ns / 1ps
module pid_address_range_table_tb;
  import part_pkg::*;

  localparam int unsigned Entries     = TableEntriesDefault;
  localparam int unsigned RangeSet    = 24;
  localparam int unsigned EpisodeLen  = 50;
  localparam int unsigned RandomItems = 450;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned CycleLimit  = 200000;
  localparam logic [AddrW-1:0] AddrMax = '1;
  localparam logic [PidW-1:0]  PidMax  = '1;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_BALANCED,
    MIX_DRAIN
  } mix_e;

  typedef struct {
    req_t req;
    bit   fixed;
    rsp_t want;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  part_req_if req_if ();
  part_rsp_if rsp_if ();

  pid_address_range_table #(
    .TABLE_ENTRIES(Entries)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  // shadow copy of the range table
  bit               tbl_valid [Entries];
  logic [PidW-1:0]  tbl_pid   [Entries];
  logic [AddrW-1:0] tbl_start [Entries];
  logic [AddrW-1:0] tbl_end   [Entries];

  rsp_t     pending_rsp [$];
  dir_row_t dir_rows [$];

  int n_mismatch, n_rsp, n_sent, cycles;
  int n_stored, n_dup, n_invalid, n_full, n_hit, n_miss, n_removed, n_not_removed;

  mix_e             ep_mode;
  logic [PidW-1:0]  ep_pid [3];
  logic [AddrW-1:0] ep_lo  [RangeSet];
  logic [AddrW-1:0] ep_hi  [RangeSet];
  bit               tx_calm, rx_calm;

  function automatic logic [AddrW-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic rsp_t table_response(req_t r);
    rsp_t res;
    bit   dup;
    int   free_idx;
    res.status = STATUS_OK;
    res.found  = 1'b0;
    dup        = 1'b0;
    free_idx   = -1;
    case (r.req_type)
      REQ_INSERT: begin
        if (r.start_addr >= r.end_addr) begin
          res.status = STATUS_INVALID;
          n_invalid++;
        end else begin
          for (int i = 0; i < Entries; i++) begin
            if (tbl_valid[i] && tbl_pid[i] == r.pid && tbl_start[i] == r.start_addr &&
                tbl_end[i] == r.end_addr)
              dup = 1'b1;
            if (!tbl_valid[i] && free_idx < 0)
              free_idx = i;
          end
          if (dup) begin
            n_dup++;
          end else if (free_idx < 0) begin
            res.status = STATUS_FULL;
            n_full++;
          end else begin
            tbl_valid[free_idx] = 1'b1;
            tbl_pid[free_idx]   = r.pid;
            tbl_start[free_idx] = r.start_addr;
            tbl_end[free_idx]   = r.end_addr;
            n_stored++;
          end
        end
      end
      REQ_LOOKUP: begin
        for (int i = 0; i < Entries; i++)
          if (tbl_valid[i] && tbl_pid[i] == r.pid && r.probe_address >= tbl_start[i] &&
              r.probe_address <= tbl_end[i])
            res.found = 1'b1;
        if (res.found) n_hit++;
        else n_miss++;
      end
      REQ_REMOVE_RANGE: begin
        if (r.start_addr < r.end_addr)
          for (int i = 0; i < Entries; i++)
            if (!res.found && tbl_valid[i] && tbl_pid[i] == r.pid &&
                tbl_start[i] == r.start_addr && tbl_end[i] == r.end_addr) begin
              tbl_valid[i] = 1'b0;
              res.found    = 1'b1;
            end
        if (res.found) n_removed++;
        else n_not_removed++;
      end
      default: begin
        for (int i = 0; i < Entries; i++)
          if (tbl_valid[i] && tbl_pid[i] == r.pid) begin
            tbl_valid[i] = 1'b0;
            res.found    = 1'b1;
          end
        if (res.found) n_removed++;
        else n_not_removed++;
      end
    endcase
    return res;
  endfunction

  function automatic void add_row(req_type_e t, logic [PidW-1:0] pid,
                                  logic [AddrW-1:0] s, logic [AddrW-1:0] e,
                                  logic [AddrW-1:0] p, bit fixed, status_e st, logic f);
    dir_row_t row;
    row.req.req_type      = t;
    row.req.pid           = pid;
    row.req.start_addr    = s;
    row.req.end_addr      = e;
    row.req.probe_address = p;
    row.fixed             = fixed;
    row.want.status       = st;
    row.want.found        = f;
    dir_rows.push_back(row);
  endfunction

  function automatic void new_episode(mix_e mode);
    logic [AddrW-1:0] base;
    ep_mode = mode;
    for (int j = 0; j < 3; j++)
      case ($urandom_range(0, 5))
        0: ep_pid[j] = '0;
        1: ep_pid[j] = PidMax;
        default: ep_pid[j] = $urandom();
      endcase
    case ($urandom_range(0, 4))
      0: base = '0;
      1: base = AddrMax - 64'd1150;
      default: base = rand64();
    endcase
    for (int k = 0; k < RangeSet; k++) begin
      ep_lo[k] = base + 64'(k * 48) + 64'($urandom_range(0, 15));
      ep_hi[k] = ep_lo[k] + 64'(1 + $urandom_range(0, 31));
    end
  endfunction

  // mostly triples from the episode pool or the live table, some pure noise
  function automatic req_t next_request();
    req_t             r;
    int               roll, j, ins_w, lkp_w, rr_w;
    int               live [$];
    logic [AddrW-1:0] lo, hi;
    r.req_type      = req_type_e'($urandom_range(0, 3));
    r.pid           = $urandom();
    r.start_addr    = rand64();
    r.end_addr      = rand64();
    r.probe_address = rand64();
    if ($urandom_range(0, 99) < 8)
      return r;
    for (int i = 0; i < Entries; i++)
      if (tbl_valid[i]) live.push_back(i);
    case (ep_mode)
      MIX_FILL: begin
        ins_w = 70; lkp_w = 20; rr_w = 7;
      end
      MIX_DRAIN: begin
        ins_w = 15; lkp_w = 30; rr_w = 35;
      end
      default: begin
        ins_w = 35; lkp_w = 35; rr_w = 20;
      end
    endcase
    j     = $urandom_range(0, RangeSet - 1);
    lo    = ep_lo[j];
    hi    = ep_hi[j];
    r.pid = ep_pid[$urandom_range(0, 2)];
    roll  = $urandom_range(0, 99);
    if (roll < ins_w) begin
      r.req_type = REQ_INSERT;
      case ($urandom_range(0, 19))
        0: begin
          r.start_addr = hi;
          r.end_addr   = lo;
        end
        1: begin
          r.start_addr = lo;
          r.end_addr   = lo;
        end
        default: begin
          r.start_addr = lo;
          r.end_addr   = hi;
        end
      endcase
    end else begin
      if (live.size() != 0 && $urandom_range(0, 99) < 60) begin
        j     = live[$urandom_range(0, live.size() - 1)];
        r.pid = tbl_pid[j];
        lo    = tbl_start[j];
        hi    = tbl_end[j];
      end
      if (roll < ins_w + lkp_w) begin
        r.req_type = REQ_LOOKUP;
        case ($urandom_range(0, 5))
          0: r.probe_address = lo;
          1: r.probe_address = hi;
          2: r.probe_address = lo - 64'd1;
          3: r.probe_address = hi + 64'd1;
          default: r.probe_address = lo + 64'($urandom_range(0, 40));
        endcase
      end else if (roll < ins_w + lkp_w + rr_w) begin
        r.req_type   = REQ_REMOVE_RANGE;
        r.start_addr = lo;
        r.end_addr   = hi;
        if ($urandom_range(0, 19) == 0) begin
          r.start_addr = hi;
          r.end_addr   = lo;
        end
      end else begin
        r.req_type = REQ_REMOVE_PID;
      end
    end
    return r;
  endfunction

  task automatic send_request(req_t r, bit fixed, rsp_t want);
    int   gap;
    rsp_t predicted;
    if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_if.valid         <= 1'b1;
    req_if.req_type      <= r.req_type;
    req_if.pid           <= r.pid;
    req_if.start_addr    <= r.start_addr;
    req_if.end_addr      <= r.end_addr;
    req_if.probe_address <= r.probe_address;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    predicted = table_response(r);
    pending_rsp.push_back(fixed ? want : predicted);
    n_sent++;
  endtask

  // response side: random stalls, with long hold-offs so the input backs up
  initial begin
    int gap;
    int taken;
    int hold_at;
    taken   = 0;
    hold_at = 20;
    wait (rst_ni === 1'b1);
    forever begin
      if (taken >= hold_at) begin
        repeat (HoldCycles) begin
          @(negedge clk_i);
          rsp_if.ready <= 1'b0;
        end
        hold_at += 230;
      end
      if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
      gap = rx_calm ? 0 : $urandom_range(0, 10);
      repeat (gap) begin
        @(negedge clk_i);
        rsp_if.ready <= 1'b0;
      end
      @(negedge clk_i);
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      taken++;
    end
  end

  always @(posedge clk_i) begin : rsp_check
    rsp_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      n_rsp++;
      if (pending_rsp.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("response %0d: transfer with nothing outstanding (status %0d found %0d)",
                   n_rsp, rsp_if.status, rsp_if.found);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_if.status !== want.status || rsp_if.found !== want.found) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("response %0d: status %0d expected %0d, found %0d expected %0d",
                     n_rsp, rsp_if.status, want.status, rsp_if.found, want.found);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles,
               pending_rsp.size());
      $display("pid_address_range_table_tb failed");
      $finish;
    end
  end

  initial begin
    req_if.valid         = 1'b0;
    req_if.req_type      = '0;
    req_if.pid           = '0;
    req_if.start_addr    = '0;
    req_if.end_addr      = '0;
    req_if.probe_address = '0;
    rsp_if.ready         = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    add_row(REQ_LOOKUP,       '0,     '0,      '0,      '0,      1'b1, STATUS_OK,      1'b0);
    add_row(REQ_LOOKUP,       PidMax, AddrMax, AddrMax, AddrMax, 1'b1, STATUS_OK,      1'b0);
    add_row(REQ_REMOVE_PID,   '0,     AddrMax, '0,      AddrMax, 1'b1, STATUS_OK,      1'b0);
    add_row(REQ_REMOVE_RANGE, 32'd5,  64'd0,   64'd1,   AddrMax, 1'b1, STATUS_OK,      1'b0);
    add_row(REQ_INSERT,       32'd5,  64'd7,   64'd7,   64'd7,   1'b1, STATUS_INVALID, 1'b0);
    add_row(REQ_INSERT,       32'd5,  AddrMax, '0,      '0,      1'b1, STATUS_INVALID, 1'b0);
    add_row(REQ_INSERT,       PidMax, '0,      AddrMax, 64'd3,   1'b1, STATUS_OK,      1'b0);
    add_row(REQ_LOOKUP,       PidMax, AddrMax, '0,      '0,      1'b1, STATUS_OK,      1'b1);
    add_row(REQ_LOOKUP,       PidMax, '0,      '0,      AddrMax, 1'b1, STATUS_OK,      1'b1);
    add_row(REQ_LOOKUP,       '0,     '0,      AddrMax, 64'd100, 1'b1, STATUS_OK,      1'b0);
    // same triple again: stored once, still reported as success
    add_row(REQ_INSERT,       PidMax, '0,      AddrMax, AddrMax, 1'b1, STATUS_OK,      1'b0);
    add_row(REQ_INSERT,       32'd1,  64'h10,  64'h20,  '0,      1'b1, STATUS_OK,      1'b0);
    add_row(REQ_LOOKUP,       32'd1,  '0,      '0,      64'h0f,  1'b1, STATUS_OK,      1'b0);
    add_row(REQ_LOOKUP,       32'd1,  '0,      '0,      64'h10,  1'b1, STATUS_OK,      1'b1);
    add_row(REQ_LOOKUP,       32'd1,  '0,      '0,      64'h20,  1'b1, STATUS_OK,      1'b1);
    add_row(REQ_LOOKUP,       32'd1,  '0,      '0,      64'h21,  1'b1, STATUS_OK,      1'b0);
    add_row(REQ_INSERT,       32'd1,  64'h18,  64'h30,  '0,      1'b0, STATUS_OK,      1'b0);
    add_row(REQ_REMOVE_RANGE, 32'd1,  64'h20,  64'h10,  '0,      1'b1, STATUS_OK,      1'b0);
    add_row(REQ_REMOVE_RANGE, 32'd1,  64'h10,  64'h20,  '0,      1'b1, STATUS_OK,      1'b1);
    add_row(REQ_REMOVE_RANGE, 32'd1,  64'h10,  64'h20,  '0,      1'b1, STATUS_OK,      1'b0);
    add_row(REQ_LOOKUP,       32'd1,  '0,      '0,      64'h19,  1'b0, STATUS_OK,      1'b0);
    add_row(REQ_REMOVE_PID,   32'd1,  '0,      '0,      '0,      1'b1, STATUS_OK,      1'b1);
    add_row(REQ_REMOVE_PID,   32'd1,  '0,      '0,      '0,      1'b1, STATUS_OK,      1'b0);
    add_row(REQ_REMOVE_PID,   PidMax, '0,      '0,      '0,      1'b1, STATUS_OK,      1'b1);
    add_row(REQ_LOOKUP,       PidMax, '0,      '0,      64'd5,   1'b1, STATUS_OK,      1'b0);

    foreach (dir_rows[i])
      send_request(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].want);

    for (int n = 0; n < RandomItems; n++) begin
      if (n % EpisodeLen == 0)
        new_episode(n == 0 ? MIX_FILL : mix_e'($urandom_range(0, 2)));
      send_request(next_request(), 1'b0, '0);
    end
    @(negedge clk_i);
    req_if.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (Entries + 8) @(posedge clk_i);

    $display("%0d requests, %0d responses: inserts %0d stored, %0d duplicate, %0d invalid, %0d full",
             n_sent, n_rsp, n_stored, n_dup, n_invalid, n_full);
    $display("lookups %0d hit, %0d miss; removals %0d found, %0d empty; %0d mismatches",
             n_hit, n_miss, n_removed, n_not_removed, n_mismatch);
    if (n_mismatch == 0) begin
      $display("pid_address_range_table_tb passed");
    end else begin
      $display("pid_address_range_table_tb failed");
    end
    $finish;
  end

endmodule
